@@ src/tcd_pkg.sv @@
// shared types and constants of the tile change detector
package tcd_pkg;

  localparam int unsigned FramePixels = 307200;
  localparam int unsigned DepthBits   = 16;

  localparam int unsigned AddrW     = 19;
  localparam int unsigned FrameIdxW = $clog2(FramePixels);
  localparam int unsigned DepthW    = 16;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned CsumW     = 10;
  localparam int unsigned DsumW     = 26;
  localparam int unsigned CaccW     = 20;
  localparam int unsigned CfgW      = 26;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [DepthW-1:0] DepthMask = DepthW'((64'd1 << DepthBits) - 64'd1);
  localparam logic [DsumW-1:0]  DsumMax   = '1;
  localparam logic [CaccW-1:0]  CaccMax   = '1;

  localparam logic [CaccW-1:0] ColorThrRst = CaccW'(8750);
  localparam logic [DsumW-1:0] DepthThrRst = DsumW'(42000);

  typedef enum logic [CfgIdxW-1:0] {
    RegColorThr = 2'd0,
    RegDepthThr = 2'd1,
    RegUseColor = 2'd2,
    RegUseDepth = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic [CsumW-1:0]  csum;
  } store_entry_t;

  typedef struct packed {
    logic              last;
    logic              in_frame;
    logic              fwd;
    store_entry_t      fwd_data;
    store_entry_t      cur;
    logic [AddrW-1:0]  addr;
  } pix_t;

  typedef struct packed {
    logic [DsumW-1:0] dsum;
    logic [CaccW-1:0] csum;
  } res_t;

endpackage

@@ src/tcd_frame_store.sv @@
// frame store of previous depth and color sum, one read and one write port
module tcd_frame_store import tcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [FrameIdxW-1:0] rd_addr_i,
  output store_entry_t         rd_data_o,
  input  logic                 wr_en_i,
  input  logic [FrameIdxW-1:0] wr_addr_i,
  input  store_entry_t         wr_data_i
);

  store_entry_t mem [FramePixels];
  store_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/tcd_diff_accum.sv @@
// absolute differences against the previous frame and saturating tile sums
module tcd_diff_accum import tcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  pix_t         pix_i,
  input  store_entry_t rd_data_i,
  output logic         push_o,
  output res_t         res_o
);

  store_entry_t      prev;
  logic [DepthW-1:0] ddiff;
  logic [CsumW-1:0]  cdiff;
  logic [DsumW:0]    dsum_wide;
  logic [CaccW:0]    csum_wide;
  logic [DsumW-1:0]  dsum_sat;
  logic [CaccW-1:0]  csum_sat;
  logic [DsumW-1:0]  dacc_q, dacc_d;
  logic [CaccW-1:0]  cacc_q, cacc_d;

  always_comb begin
    if (!pix_i.in_frame) begin
      prev = '0;
    end else if (pix_i.fwd) begin
      prev = pix_i.fwd_data;
    end else begin
      prev = rd_data_i;
    end
  end

  assign ddiff = (pix_i.cur.depth > prev.depth) ? pix_i.cur.depth - prev.depth
                                                : prev.depth - pix_i.cur.depth;
  assign cdiff = (pix_i.cur.csum > prev.csum) ? pix_i.cur.csum - prev.csum
                                              : prev.csum - pix_i.cur.csum;

  assign dsum_wide = {1'b0, dacc_q} + (DsumW+1)'(ddiff);
  assign csum_wide = {1'b0, cacc_q} + (CaccW+1)'(cdiff);
  assign dsum_sat  = dsum_wide[DsumW] ? DsumMax : dsum_wide[DsumW-1:0];
  assign csum_sat  = csum_wide[CaccW] ? CaccMax : csum_wide[CaccW-1:0];

  always_comb begin
    dacc_d = dacc_q;
    cacc_d = cacc_q;
    if (valid_i) begin
      dacc_d = pix_i.last ? '0 : dsum_sat;
      cacc_d = pix_i.last ? '0 : csum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dacc_q <= '0;
      cacc_q <= '0;
    end else begin
      dacc_q <= dacc_d;
      cacc_q <= cacc_d;
    end
  end

  assign push_o     = valid_i & pix_i.last;
  assign res_o.dsum = dsum_sat;
  assign res_o.csum = csum_sat;

endmodule

@@ src/tcd_out_buf.sv @@
// two-entry result buffer between the sums and the output channel
module tcd_out_buf import tcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_t       data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output res_t       data_o,
  output logic [1:0] count_o
);

  res_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o & ready_i;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

@@ src/tile_change_detector.sv @@
// Tile change detector top level. Sustains one pixel beat per clock: each beat
// reads the frame store at its address in the accept cycle and writes the new
// depth and color sum back in the next, with the write forwarded when the next
// pixel hits the same address. The result beat of a tile is registered in the
// s1 stage register and then in a two-entry result buffer; input stalls when
// that buffer would hold two results in the next cycle, so a receiver that
// keeps taking result beats never stalls the input.
// After reset the frame store is cleared one entry per cycle, over all 307200
// entries, during which no pixel is accepted (configuration writes are taken).
module tile_change_detector import tcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [AddrW-1:0]   pixel_addr_i,
  input  logic [DepthW-1:0]  depth_i,
  input  logic [ColorW-1:0]  red_i,
  input  logic [ColorW-1:0]  green_i,
  input  logic [ColorW-1:0]  blue_i,
  input  logic               last_in_tile_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               tile_changed_o,
  output logic [DsumW-1:0]   depth_diff_sum_o,
  output logic [CaccW-1:0]   color_diff_sum_o
);

  logic [CaccW-1:0] color_thr_q;
  logic [DsumW-1:0] depth_thr_q;
  logic             use_color_q, use_depth_q;

  logic                 clr_busy_q;
  logic [FrameIdxW-1:0] clr_idx_q;

  logic         in_acc;
  logic         in_frame;
  store_entry_t cur_entry;
  logic         s1_valid_q;
  pix_t         s1_q;

  logic                 mem_we;
  logic [FrameIdxW-1:0] mem_waddr;
  store_entry_t         mem_wdata;
  store_entry_t         rd_data;

  logic       acc_push;
  res_t       acc_res;
  res_t       out_res;
  logic [1:0] buf_cnt;
  logic       out_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_thr_q <= ColorThrRst;
      depth_thr_q <= DepthThrRst;
      use_color_q <= 1'b1;
      use_depth_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegColorThr: color_thr_q <= cfg_wdata_i[CaccW-1:0];
        RegDepthThr: depth_thr_q <= cfg_wdata_i[DsumW-1:0];
        RegUseColor: use_color_q <= cfg_wdata_i[0];
        RegUseDepth: use_depth_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clearing pass over the frame store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == FrameIdxW'(FramePixels - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  assign out_pop    = out_valid_o & out_ready_i;
  assign in_ready_o = !clr_busy_q &&
                      ((buf_cnt + 2'(s1_valid_q & s1_q.last)) <= (2'd1 + 2'(out_pop)));
  assign in_acc     = in_valid_i & in_ready_o;
  assign in_frame   = {1'b0, pixel_addr_i} < (AddrW+1)'(FramePixels);

  assign cur_entry.depth = depth_i & DepthMask;
  assign cur_entry.csum  = CsumW'(red_i) + CsumW'(green_i) + CsumW'(blue_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.last     <= last_in_tile_i;
      s1_q.in_frame <= in_frame;
      s1_q.fwd      <= s1_valid_q & s1_q.in_frame & (s1_q.addr == pixel_addr_i);
      s1_q.fwd_data <= s1_q.cur;
      s1_q.cur      <= cur_entry;
      s1_q.addr     <= pixel_addr_i;
    end
  end

  // write back of the current pixel, or zeros while clearing
  assign mem_we    = clr_busy_q | (s1_valid_q & s1_q.in_frame);
  assign mem_waddr = clr_busy_q ? clr_idx_q : s1_q.addr[FrameIdxW-1:0];
  assign mem_wdata = clr_busy_q ? '0 : s1_q.cur;

  tcd_frame_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (pixel_addr_i[FrameIdxW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  tcd_diff_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .pix_i     (s1_q),
    .rd_data_i (rd_data),
    .push_o    (acc_push),
    .res_o     (acc_res)
  );

  tcd_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc_push),
    .data_i  (acc_res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res),
    .count_o (buf_cnt)
  );

  assign depth_diff_sum_o = out_res.dsum;
  assign color_diff_sum_o = out_res.csum;
  assign tile_changed_o   = (use_color_q && (out_res.csum > color_thr_q)) ||
                            (use_depth_q && (out_res.dsum > depth_thr_q));

`ifndef SYNTH
  a_no_pixel_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !clr_busy_q && !mem_we || !clr_busy_q
  ) else $error("pixel beat accepted during frame store clearing");

  a_buf_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    acc_push && !(out_valid_o && out_ready_i) |-> buf_cnt < 2'd2
  ) else $error("result buffer overflow");

  a_clear_ends_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> !s1_valid_q && buf_cnt == 2'd0
  ) else $error("pipeline active at end of clearing pass");
`endif

endmodule

@@ tb/sv/tile_change_detector_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the tile change detector: directed and random pixel traffic
module tile_change_detector_test;
  import tcd_pkg::*;

  localparam int          ClkPeriod     = 4;
  localparam longint      TimeoutCycles = 1_500_000;
  localparam int          DrainCycles   = 8;
  localparam int unsigned SatPixels     = 1400;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [DepthW-1:0] depth;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              last;
  } pixel_beat_t;

  typedef struct packed {
    logic             changed;
    logic [DsumW-1:0] dsum;
    logic [CaccW-1:0] csum;
  } tile_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [AddrW-1:0]   pixel_addr_i = '0;
  logic [DepthW-1:0]  depth_i = '0;
  logic [ColorW-1:0]  red_i = '0;
  logic [ColorW-1:0]  green_i = '0;
  logic [ColorW-1:0]  blue_i = '0;
  logic               last_in_tile_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               tile_changed_o;
  logic [DsumW-1:0]   depth_diff_sum_o;
  logic [CaccW-1:0]   color_diff_sum_o;

  tile_change_detector u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_addr_i     (pixel_addr_i),
    .depth_i          (depth_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .last_in_tile_i   (last_in_tile_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tile_changed_o   (tile_changed_o),
    .depth_diff_sum_o (depth_diff_sum_o),
    .color_diff_sum_o (color_diff_sum_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // shadow frame store, tile sums and register copies
  bit [DepthW-1:0]   prev_depth_mem [FramePixels];
  bit [CsumW-1:0]    prev_csum_mem  [FramePixels];
  logic [DsumW-1:0]  depth_acc = '0;
  logic [CaccW-1:0]  color_acc = '0;
  logic [CaccW-1:0]  color_thr_reg = ColorThrRst;
  logic [DsumW-1:0]  depth_thr_reg = DepthThrRst;
  logic              use_color_reg = 1'b1;
  logic              use_depth_reg = 1'b1;
  tile_result_t      pending_tiles_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned out_hold_cycles = 0;

  int unsigned n_errors = 0;
  int unsigned n_pixels = 0;
  int unsigned n_out_of_frame = 0;
  int unsigned n_tiles_checked = 0;
  int unsigned n_changed = 0;
  int unsigned n_saturated = 0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    n_errors++;
    if (n_errors <= 40)
      $display("%0t ns: tile %0d %s: got %0d, expected %0d",
               $time, n_tiles_checked, what, got, want);
  endtask

  task automatic accumulate_pixel(input pixel_beat_t px);
    logic [DepthW-1:0] d;
    logic [DepthW-1:0] pd;
    logic [DepthW-1:0] ddiff;
    logic [CsumW-1:0]  cs;
    logic [CsumW-1:0]  pc;
    logic [CsumW-1:0]  cdiff;
    logic [DsumW:0]    depth_wide;
    logic [CaccW:0]    color_wide;
    tile_result_t      res;
    d  = px.depth & DepthMask;
    cs = CsumW'(px.red) + CsumW'(px.green) + CsumW'(px.blue);
    pd = '0;
    pc = '0;
    n_pixels++;
    if (px.addr < AddrW'(FramePixels)) begin
      pd = prev_depth_mem[px.addr];
      pc = prev_csum_mem[px.addr];
      prev_depth_mem[px.addr] = d;
      prev_csum_mem[px.addr]  = cs;
    end else begin
      n_out_of_frame++;
    end
    ddiff = (d > pd) ? d - pd : pd - d;
    cdiff = (cs > pc) ? cs - pc : pc - cs;
    depth_wide = {1'b0, depth_acc} + (DsumW+1)'(ddiff);
    color_wide = {1'b0, color_acc} + (CaccW+1)'(cdiff);
    depth_acc = (depth_wide > DsumMax) ? DsumMax : depth_wide[DsumW-1:0];
    color_acc = (color_wide > CaccMax) ? CaccMax : color_wide[CaccW-1:0];
    if (px.last) begin
      res.changed = (use_color_reg && color_acc > color_thr_reg) ||
                    (use_depth_reg && depth_acc > depth_thr_reg);
      res.dsum = depth_acc;
      res.csum = color_acc;
      if (depth_acc == DsumMax || color_acc == CaccMax) n_saturated++;
      pending_tiles_q.push_back(res);
      depth_acc = '0;
      color_acc = '0;
    end
  endtask

  // result beat checker
  always @(posedge clk_i) begin : result_check
    tile_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tiles_q.size() == 0) begin
        report_mismatch("result beat with no tile pending", depth_diff_sum_o, 0);
      end else begin
        want = pending_tiles_q.pop_front();
        if (tile_changed_o !== want.changed)
          report_mismatch("tile_changed", tile_changed_o, want.changed);
        if (depth_diff_sum_o !== want.dsum)
          report_mismatch("depth_diff_sum", depth_diff_sum_o, want.dsum);
        if (color_diff_sum_o !== want.csum)
          report_mismatch("color_diff_sum", color_diff_sum_o, want.csum);
        if (want.changed) n_changed++;
      end
      n_tiles_checked++;
    end
  end

  // output side stalls, with a long hold-off on request
  always @(posedge clk_i) begin
    if (out_hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      out_hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pixel(input pixel_beat_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_addr_i   <= px.addr;
    depth_i        <= px.depth;
    red_i          <= px.red;
    green_i        <= px.green;
    blue_i         <= px.blue;
    last_in_tile_i <= px.last;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_pixel(px);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_tiles_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CaccW-1:0] color_thr, input logic [DsumW-1:0] depth_thr,
                           input logic use_c, input logic use_d);
    logic [CfgW-1:0] junk;
    junk = CfgW'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegColorThr;
    cfg_wdata_i <= {junk[CfgW-1:CaccW], color_thr};
    @(posedge clk_i);
    cfg_index_i <= RegDepthThr;
    cfg_wdata_i <= depth_thr;
    @(posedge clk_i);
    junk = CfgW'($urandom);
    cfg_index_i <= RegUseColor;
    cfg_wdata_i <= {junk[CfgW-1:1], use_c};
    @(posedge clk_i);
    junk = CfgW'($urandom);
    cfg_index_i <= RegUseDepth;
    cfg_wdata_i <= {junk[CfgW-1:1], use_d};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    color_thr_reg = color_thr;
    depth_thr_reg = depth_thr;
    use_color_reg = use_c;
    use_depth_reg = use_d;
  endtask

  function automatic pixel_beat_t make_pixel(input logic [AddrW-1:0] addr,
                                             input logic [DepthW-1:0] depth,
                                             input logic [ColorW-1:0] r, input logic [ColorW-1:0] g,
                                             input logic [ColorW-1:0] b, input logic last);
    pixel_beat_t px;
    px.addr  = addr;
    px.depth = depth;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    px.last  = last;
    return px;
  endfunction

  function automatic logic [ColorW-1:0] rand_color();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return ColorW'($urandom);
  endfunction

  task automatic run_traffic(input int unsigned n_beats, input logic [AddrW-1:0] base,
                             input int unsigned max_len);
    pixel_beat_t      px;
    logic [AddrW-1:0] prev_addr;
    int unsigned      left_in_tile;
    int unsigned      sent;
    int unsigned      sel;
    prev_addr    = base;
    left_in_tile = 0;
    sent         = 0;
    while (sent < n_beats || left_in_tile != 0) begin
      if (left_in_tile == 0)
        left_in_tile = ($urandom_range(99) < 85) ? $urandom_range(1, max_len)
                                                 : $urandom_range(1, 4 * max_len);
      sel = $urandom_range(99);
      if (sel < 45)      px.addr = base + AddrW'($urandom_range(31));
      else if (sel < 65) px.addr = prev_addr;
      else if (sel < 80) px.addr = prev_addr + 1'b1;
      else if (sel < 92) px.addr = AddrW'($urandom);
      else               px.addr = AddrW'(FramePixels - 4 + $urandom_range(7));
      sel = $urandom_range(99);
      if (sel < 10)      px.depth = '0;
      else if (sel < 20) px.depth = '1;
      else               px.depth = DepthW'($urandom);
      px.red   = rand_color();
      px.green = rand_color();
      px.blue  = rand_color();
      px.last  = (left_in_tile == 1);
      left_in_tile--;
      prev_addr = px.addr;
      send_pixel(px);
      sent++;
    end
  endtask

  task automatic test_reset_values();
    send_pixel(make_pixel(0, '1, '1, '1, '1, 1'b1));
    send_pixel(make_pixel(1, '0, '0, '0, '0, 1'b1));
    send_pixel(make_pixel(0, '0, '0, '0, '0, 1'b1));
  endtask

  task automatic test_field_extremes();
    send_pixel(make_pixel(AddrW'(FramePixels - 1), 16'h5555, 8'hAA, 8'h55, 8'hFF, 1'b0));
    send_pixel(make_pixel(AddrW'(FramePixels - 1), 16'hAAAA, 8'h55, 8'hAA, 8'h00, 1'b0));
    send_pixel(make_pixel(AddrW'(FramePixels), '1, '1, '1, '1, 1'b0));
    send_pixel(make_pixel('1, 16'd1, 8'd1, 8'd2, 8'd3, 1'b0));
    send_pixel(make_pixel(AddrW'(FramePixels), 16'd7, 8'd9, 8'd0, 8'd4, 1'b1));
    send_pixel(make_pixel(AddrW'(FramePixels - 1), '0, '0, '0, '0, 1'b1));
  endtask

  // thresholds are strict, each criterion gated by its enable
  task automatic test_threshold_edges();
    logic [AddrW-1:0] off_frame;
    off_frame = AddrW'(FramePixels + 5);
    wait_idle();
    configure(300, 1000, 1'b1, 1'b0);
    send_pixel(make_pixel(off_frame, 16'd5000, 8'd100, 8'd100, 8'd100, 1'b1));
    send_pixel(make_pixel(off_frame, 16'd5000, 8'd100, 8'd100, 8'd101, 1'b1));
    wait_idle();
    configure(CaccMax, 1000, 1'b0, 1'b1);
    send_pixel(make_pixel(off_frame, 16'd1000, '1, '1, '1, 1'b1));
    send_pixel(make_pixel(off_frame, 16'd1001, '0, '0, '0, 1'b1));
    wait_idle();
    configure(0, 0, 1'b0, 1'b0);
    send_pixel(make_pixel(off_frame, '1, '1, '1, '1, 1'b1));
    wait_idle();
    configure(0, 0, 1'b1, 1'b1);
    send_pixel(make_pixel(off_frame, '0, '0, '0, '0, 1'b1));
    send_pixel(make_pixel(off_frame, '0, '0, '0, 8'd1, 1'b1));
    wait_idle();
    configure(CaccMax, DsumMax, 1'b1, 1'b1);
    send_pixel(make_pixel(off_frame, '1, '1, '1, '1, 1'b1));
  endtask

  task automatic test_saturation();
    wait_idle();
    configure(CaccMax - 1'b1, DsumMax - 1'b1, 1'b1, 1'b1);
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    for (int unsigned i = 0; i < SatPixels; i++)
      send_pixel(make_pixel(AddrW'(FramePixels + 16), '1, '1, '1, '1, i == SatPixels - 1));
    send_pixel(make_pixel(AddrW'(FramePixels + 16), 16'd3, 8'd1, 8'd1, 8'd1, 1'b1));
  endtask

  // hold the output while tiles keep coming so the input has to stall
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    out_hold_cycles = 600;
    run_traffic(40, 64, 1);
  endtask

  task automatic test_random_mix();
    logic [AddrW-1:0] base;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;  base = 0;
          configure(700, 100000, 1'b1, 1'b1);
        end
        1: begin
          send_idle_pct = 60; recv_stall_pct = 0;  base = 1000;
          configure(0, DsumMax, 1'b1, 1'b0);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 60; base = AddrW'(FramePixels - 16);
          configure(CaccMax, 0, 1'b0, 1'b1);
        end
        default: begin
          send_idle_pct = 33; recv_stall_pct = 33; base = AddrW'(200000);
          configure(CaccW'($urandom_range(400, 2500)), DsumW'($urandom_range(20000, 300000)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      endcase
      run_traffic(125, base, 8);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_field_extremes();
    test_threshold_edges();
    test_saturation();
    test_backpressure();
    test_random_mix();
    wait_idle();
    $display("covered %0d pixel beats, %0d of them outside the frame, under several settings",
             n_pixels, n_out_of_frame);
    $display("checked %0d tile results: %0d flagged changed, %0d with a saturated sum",
             n_tiles_checked, n_changed, n_saturated);
    if (n_errors == 0 && pending_tiles_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d tile results still pending", pending_tiles_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
